// File: src/ptest_pkg.sv
// Shared constants, types and modular add helper for the 64-bit primality tester.
// No dependencies.
package ptest_pkg;

    localparam int NumPrimes  = 12;
    localparam int NumBases   = 7;
    localparam int WordW      = 64;
    localparam int RemW       = 6;
    localparam int IdxW       = 3;
    localparam int CntW       = 6;
    localparam int TrialBits  = 4;
    localparam int TrialSteps = WordW / TrialBits;

    localparam logic [RemW-1:0] SMALL_PRIMES [NumPrimes] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

    localparam logic [WordW-1:0] MR_BASES [NumBases] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
    };

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRIAL = 9'b000000010,
        S_EVAL  = 9'b000000100,
        S_SPLIT = 9'b000001000,
        S_RED   = 9'b000010000,
        S_POW   = 9'b000100000,
        S_SQ    = 9'b001000000,
        S_MWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        RET_RED  = 2'd0,
        RET_PMUL = 2'd1,
        RET_PSQR = 2'd2,
        RET_SQR  = 2'd3
    } t_ret;

    // (x + y) mod m for x, y < m
    function automatic logic [WordW-1:0] add_mod(input logic [WordW-1:0] x,
                                                 input logic [WordW-1:0] y,
                                                 input logic [WordW-1:0] m);
        logic [WordW-1:0] gap;
        gap = m - y;
        return (x >= gap) ? (x - gap) : (x + y);
    endfunction

endpackage

// File: src/primality_test_64bit_core.sv
// Deterministic Miller-Rabin primality test for one 64-bit candidate per beat.
// Trial division (4 bits a cycle), then splitting n-1 into d * 2^s, then per base a base
// reduction plus modular products (a square chained behind a multiply; up to 2 per exponent
// bit plus up to s-1 squarings), all on one shared bit-serial multiplier. One candidate at a time.
// Sync active-low reset -> idle.
// Depends on ptest_pkg and ptest_mulmod.
module primality_test_64bit_core
    import ptest_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [WordW-1:0] s_axis_tdata,   // [63:0] candidate
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] is_prime, [7:1] zero
);

    t_state r_state;
    t_ret   r_ret;
    logic [WordW-1:0] r_n, r_d, r_res, r_b, r_e, r_x;
    logic [RemW-1:0]  r_rem [NumPrimes];
    logic [CntW-1:0]  r_cnt, r_s, r_r;
    logic [IdxW-1:0]  r_idx;
    logic             r_prime, r_out_valid, r_out;

    logic             w_start, w_mdone;
    logic [WordW-1:0] w_mx, w_my, w_mres;
    logic             w_found, w_hit_eq;
    logic [RemW:0]    w_t [NumPrimes];

    ptest_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_x      (w_mx),
        .i_y      (w_my),
        .i_m      (r_n),
        .o_done   (w_mdone),
        .o_result (w_mres)
    );

    always_comb begin
        for (int i = 0; i < NumPrimes; i++) begin
            w_t[i] = {1'b0, r_rem[i]};
            for (int b = 0; b < TrialBits; b++) begin
                w_t[i] = {w_t[i][RemW-1:0], r_d[WordW-1-b]};
                if (w_t[i] >= {1'b0, SMALL_PRIMES[i]}) begin
                    w_t[i] = w_t[i] - {1'b0, SMALL_PRIMES[i]};
                end
            end
        end
        w_found  = 1'b0;
        w_hit_eq = 1'b0;
        for (int i = 0; i < NumPrimes; i++) begin
            if (!w_found && r_rem[i] == '0) begin
                w_found  = 1'b1;
                w_hit_eq = (r_n == {{(WordW-RemW){1'b0}}, SMALL_PRIMES[i]});
            end
        end
    end

    always_comb begin
        w_start = 1'b0;
        w_mx    = r_b;
        w_my    = r_b;
        case (r_state)
            S_RED: begin
                w_start = 1'b1;
                w_mx    = {{(WordW-1){1'b0}}, 1'b1};
                w_my    = MR_BASES[r_idx];
            end
            S_POW: begin
                if (r_e != '0) begin
                    w_start = 1'b1;
                    w_mx    = r_e[0] ? r_res : r_b;
                end
            end
            S_SQ: begin
                if (r_r < r_s) begin
                    w_start = 1'b1;
                    w_mx    = r_x;
                    w_my    = r_x;
                end
            end
            S_MWAIT: begin
                w_start = w_mdone && (r_ret == RET_PMUL);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_TRIAL;
                    end
                end
                S_TRIAL: begin
                    if (r_cnt == CntW'(TrialSteps - 1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_n < 64'd2) begin
                        r_state <= S_DONE;
                    end else if (w_found) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (r_d[0]) begin
                        r_state <= S_RED;
                    end
                end
                S_RED: r_state <= S_MWAIT;
                S_POW: begin
                    if (r_e != '0) begin
                        r_state <= S_MWAIT;
                    end else if (r_res == 64'd1 || r_res == r_n - 1'b1) begin
                        r_state <= (r_idx == IdxW'(NumBases - 1)) ? S_DONE : S_RED;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= (r_r < r_s) ? S_MWAIT : S_DONE;
                end
                S_MWAIT: begin
                    if (w_mdone) begin
                        case (r_ret)
                            RET_RED: begin
                                if (w_mres == '0) begin
                                    r_state <= (r_idx == IdxW'(NumBases - 1)) ? S_DONE : S_RED;
                                end else begin
                                    r_state <= S_POW;
                                end
                            end
                            RET_PMUL: r_state <= S_MWAIT;
                            RET_PSQR: r_state <= S_POW;
                            RET_SQR: begin
                                if (w_mres == r_n - 1'b1) begin
                                    r_state <= (r_idx == IdxW'(NumBases - 1)) ? S_DONE : S_RED;
                                end else begin
                                    r_state <= S_SQ;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n   <= s_axis_tdata;
                r_d   <= s_axis_tdata;
                r_cnt <= '0;
                for (int i = 0; i < NumPrimes; i++) begin
                    r_rem[i] <= '0;
                end
            end
            S_TRIAL: begin
                r_cnt <= r_cnt + 1'b1;
                r_d   <= r_d << TrialBits;
                for (int i = 0; i < NumPrimes; i++) begin
                    r_rem[i] <= w_t[i][RemW-1:0];
                end
            end
            S_EVAL: begin
                r_prime <= (r_n >= 64'd2) && w_hit_eq;
                r_d     <= r_n - 1'b1;
                r_s     <= '0;
                r_idx   <= '0;
            end
            S_SPLIT: begin
                if (!r_d[0]) begin
                    r_d <= {1'b0, r_d[WordW-1:1]};
                    r_s <= r_s + 1'b1;
                end
            end
            S_RED: r_ret <= RET_RED;
            S_POW: begin
                if (r_e != '0) begin
                    r_ret <= r_e[0] ? RET_PMUL : RET_PSQR;
                end else if (r_res == 64'd1 || r_res == r_n - 1'b1) begin
                    r_prime <= 1'b1;
                    r_idx   <= r_idx + 1'b1;
                end else begin
                    r_x <= r_res;
                    r_r <= CntW'(1);
                end
            end
            S_SQ: begin
                r_ret <= RET_SQR;
                if (r_r >= r_s) begin
                    r_prime <= 1'b0;
                end
            end
            S_MWAIT: begin
                if (w_mdone) begin
                    case (r_ret)
                        RET_RED: begin
                            r_prime <= 1'b1;
                            if (w_mres == '0) begin
                                r_idx <= r_idx + 1'b1;
                            end
                            r_res <= 64'd1;
                            r_b   <= w_mres;
                            r_e   <= r_d;
                        end
                        RET_PMUL: begin
                            r_res <= w_mres;
                            r_ret <= RET_PSQR;
                        end
                        RET_PSQR: begin
                            r_b <= w_mres;
                            r_e <= {1'b0, r_e[WordW-1:1]};
                        end
                        RET_SQR: begin
                            r_prime <= 1'b1;
                            r_x     <= w_mres;
                            r_r     <= r_r + 1'b1;
                            if (w_mres == r_n - 1'b1) begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    r_out <= r_prime;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    a_mdone_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> (r_state == S_MWAIT)) else $error("product done outside wait");
    a_accept_trial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_TRIAL))
        else $error("accepted beat did not start trial division");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> r_out_valid)
        else $error("finished result not presented");

endmodule

// File: src/ptest_mulmod.sv
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle.
// Depends on ptest_pkg.
module ptest_mulmod
    import ptest_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WordW-1:0] i_x,
    input  logic [WordW-1:0] i_y,
    input  logic [WordW-1:0] i_m,
    output logic             o_done,
    output logic [WordW-1:0] o_result
);

    logic [WordW-1:0] r_acc, r_x, r_y, r_m;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy, r_done;
    logic [WordW-1:0] w_dbl, w_step;

    always_comb begin
        w_dbl  = add_mod(r_acc, r_acc, r_m);
        w_step = r_y[WordW-1] ? add_mod(w_dbl, r_x, r_m) : w_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(WordW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= w_step;
            r_y   <= {r_y[WordW-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_done_lt_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < r_m)) else $error("mulmod result not reduced");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("mulmod restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("mulmod done held");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for primality_test_64bit_core: directed table plus random candidates,
// each result checked against an in-bench Miller-Rabin predictor. Depends on ptest_pkg and the core.
module testbench
    import ptest_pkg::*;
();

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [WordW-1:0] s_axis_tdata = '0;   // [63:0] candidate
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;        // [0] is_prime, [7:1] zero

    primality_test_64bit_core DUT (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [63:0] cand;
        int          want;  // -1: use predictor
    } t_row;

    localparam int NRows = 22;
    localparam int NRand = 118;
    localparam int NPrime = 12;
    localparam int NMr = 7;
    localparam logic [63:0] SmallP [NPrime] =
        '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    localparam logic [63:0] MrBase [NMr] =
        '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    localparam logic [63:0] KnownPrimes [6] = '{
        64'd18446744073709551557, 64'd1000000007, 64'd4294967291,
        64'd9223372036854775783, 64'd2305843009213693951, 64'd998244353};

    t_row rows [NRows] = '{
        '{64'd0, 0}, '{64'd1, 0}, '{64'd2, 1}, '{64'd3, 1}, '{64'd4, 0},
        '{64'd37, 1}, '{64'd41, 1}, '{64'd74, 0}, '{64'd1369, 0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 0}, '{64'd18446744073709551557, -1},
        '{64'h8000_0000_0000_0000, 0}, '{64'd3215031751, -1}, '{64'd325, 0},
        '{64'd1795265022, 0}, '{64'd2047, -1}, '{64'd1373653, -1},
        '{64'd3825123056546413051, -1}, '{64'd43, 1}, '{64'd2305843009213693951, -1},
        '{64'hAAAA_AAAA_AAAA_AAAB, -1}, '{64'h5555_5555_5555_5555, 0}};

    logic expected_q [$];
    int   errors = 0;
    int   cycles = 0;
    int   stall_left = 0;
    bit   quiet = 1'b0;

    function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] r;
        r = 64'd1;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic prime_of(logic [63:0] n);
        logic [63:0] d, x, a;
        int s;
        bit comp;
        if (n < 2) return 1'b0;
        for (int i = 0; i < NPrime; i++)
            if (n % SmallP[i] == 0) return n == SmallP[i];
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < NMr; i++) begin
            a = MrBase[i] % n;
            if (a == 0) continue;
            x = powmod(a, d, n);
            if (x == 1 || x == n - 1) continue;
            comp = 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mulmod(x, x, n);
                if (x == n - 1) begin
                    comp = 1'b0;
                    break;
                end
            end
            if (comp) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_cand();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = rand64();
            1: v = rand64() | 64'd1;
            2: v = 64'($urandom_range(0, 2000));
            3: v = KnownPrimes[$urandom_range(0, 5)];
            4: v = 64'($urandom) | 64'd1;
            default: v = rand64() >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    task automatic send(logic [63:0] c, int want);
        logic p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        p = prime_of(c);
        if (want >= 0 && p !== want[0]) begin
            $display("%0t predictor table mismatch for %0d: expected %0d actual %0d",
                     $time, c, want, p);
            errors++;
        end
        if (want >= 0) p = want[0];
        s_axis_tdata  <= c;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q = {expected_q, p};
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            m_axis_tready <= i_rst_n;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= (stall_left == 0);
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                logic e;
                e = expected_q.pop_front();
                if (m_axis_tdata !== {7'd0, e}) begin
                    $display("%0t is_prime mismatch: expected %h actual %h",
                             $time, {7'd0, e}, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 40000000) begin
            $display("[primality_test_64bit_core] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < NRows; i++) send(rows[i].cand, rows[i].want);
        for (int i = 0; i < NRand; i++) begin
            if (i == NRand - 20) quiet = 1'b1;
            send(rand_cand(), -1);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("[primality_test_64bit_core] OK");
        else $display("[primality_test_64bit_core] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
src/ptest_pkg.sv
src/ptest_mulmod.sv
src/primality_test_64bit_core.sv
test/testbench.sv
